// ===== src/aksd_pkg.sv =====
// ----------------------------------------------------------------------------
// aksd_pkg
// Types, constants and the sequence transition function shared by the
// escape sequence key decoder modules.
// ----------------------------------------------------------------------------
package aksd_pkg;

	localparam int unsigned AKSD_QUEUE_DEPTH = 2;

	localparam logic [7:0] ESC_BYTE        = 8'h1B;
	localparam logic [7:0] TIMEOUT_RESET   = 8'd10;
	localparam logic [7:0] WAIT_MAX        = 8'd255;
	localparam logic [2:0] REPLAY_MAX      = 3'd4;

	// Parser states. Codes from 11 to 30 are the digit states that expect '~'.
	typedef logic [4:0] pstate_t;
	localparam pstate_t ST_IDLE    = 5'd0;
	localparam pstate_t ST_ESC     = 5'd1;
	localparam pstate_t ST_SS3     = 5'd2;
	localparam pstate_t ST_CSI     = 5'd3;
	localparam pstate_t ST_ONE     = 5'd4;
	localparam pstate_t ST_TWO     = 5'd5;
	localparam pstate_t ST_THREE   = 5'd6;
	localparam pstate_t ST_FOUR    = 5'd7;
	localparam pstate_t ST_FIVE    = 5'd8;
	localparam pstate_t ST_SIX     = 5'd9;
	localparam pstate_t ST_BRACKET2 = 5'd10;
	localparam pstate_t ST_NUM_LO  = 5'd11;
	localparam pstate_t ST_NUM_HI  = 5'd30;

	// Key ids.
	localparam logic [4:0] KEY_UP     = 5'd20;
	localparam logic [4:0] KEY_DOWN   = 5'd21;
	localparam logic [4:0] KEY_RIGHT  = 5'd22;
	localparam logic [4:0] KEY_LEFT   = 5'd23;
	localparam logic [4:0] KEY_END    = 5'd24;
	localparam logic [4:0] KEY_HOME   = 5'd25;
	localparam logic [4:0] KEY_INSERT = 5'd26;
	localparam logic [4:0] KEY_PGUP   = 5'd27;
	localparam logic [4:0] KEY_PGDN   = 5'd28;
	localparam logic [4:0] CHAR_DEL   = 5'd8;

	// Next state after a second digit, and after the first digit.
	localparam pstate_t NEXT_AFTER_1 [9] = '{5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
		5'd0, 5'd16, 5'd17, 5'd18};
	localparam pstate_t NEXT_AFTER_2 [10] = '{5'd19, 5'd20, 5'd0, 5'd21, 5'd22,
		5'd23, 5'd24, 5'd0, 5'd25, 5'd26};
	localparam pstate_t NEXT_AFTER_3 [4] = '{5'd27, 5'd28, 5'd29, 5'd30};
	localparam pstate_t NEXT_AFTER_BRACKET [6] = '{5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9};

	typedef enum logic [1:0] {
		TR_BAD,
		TR_CONT,
		TR_KEY,
		TR_CHAR
	} tr_code_t;

	typedef struct packed {
		tr_code_t   code;
		pstate_t    ns;
		logic [4:0] res;
	} trans_t;

	// Command from the parser to the result stage: replayed bytes first,
	// then an optional tail result.
	typedef struct packed {
		logic [2:0]      rcnt;
		logic [3:0][7:0] rbytes;
		logic            tail;
		logic            tail_special;
		logic [7:0]      tail_char;
		logic [4:0]      tail_key;
	} cmd_t;

	// One parser step for a received byte in a sequence state.
	function automatic trans_t transition(pstate_t st, logic [7:0] b);
		trans_t     t;
		logic [7:0] d;
		pstate_t    nx;
		t  = '{code: TR_BAD, ns: ST_IDLE, res: 5'd0};
		nx = ST_IDLE;
		case (st)
			ST_ESC: begin
				if (b == "O") begin
					t.code = TR_CONT;
					t.ns   = ST_SS3;
				end else if (b == "[") begin
					t.code = TR_CONT;
					t.ns   = ST_CSI;
				end
			end
			ST_SS3: begin
				if (b inside {["P":"S"]}) begin
					d      = b - 8'("P");
					t.code = TR_KEY;
					t.res  = d[4:0];
				end
			end
			ST_CSI: begin
				case (b)
					"A": begin t.code = TR_KEY; t.res = KEY_UP; end
					"B": begin t.code = TR_KEY; t.res = KEY_DOWN; end
					"C": begin t.code = TR_KEY; t.res = KEY_RIGHT; end
					"D": begin t.code = TR_KEY; t.res = KEY_LEFT; end
					"F": begin t.code = TR_KEY; t.res = KEY_END; end
					"H": begin t.code = TR_KEY; t.res = KEY_HOME; end
					"[": begin t.code = TR_CONT; t.ns = ST_BRACKET2; end
					default: begin
						if (b inside {["1":"6"]}) begin
							d      = b - 8'("1");
							t.code = TR_CONT;
							t.ns   = NEXT_AFTER_BRACKET[d[2:0]];
						end
					end
				endcase
			end
			ST_ONE: begin
				if (b == "~") begin
					t.code = TR_KEY;
					t.res  = KEY_HOME;
				end else if (b inside {["1":"9"]}) begin
					d  = b - 8'("1");
					nx = NEXT_AFTER_1[d[3:0]];
				end
			end
			ST_TWO: begin
				if (b == "~") begin
					t.code = TR_KEY;
					t.res  = KEY_INSERT;
				end else if (b inside {["0":"9"]}) begin
					d  = b - 8'("0");
					nx = NEXT_AFTER_2[d[3:0]];
				end
			end
			ST_THREE: begin
				if (b == "~") begin
					t.code = TR_CHAR;
					t.res  = CHAR_DEL;
				end else if (b inside {["1":"4"]}) begin
					d  = b - 8'("1");
					nx = NEXT_AFTER_3[d[1:0]];
				end
			end
			ST_FOUR: begin
				if (b == "~") begin t.code = TR_KEY; t.res = KEY_END; end
			end
			ST_FIVE: begin
				if (b == "~") begin t.code = TR_KEY; t.res = KEY_PGUP; end
			end
			ST_SIX: begin
				if (b == "~") begin t.code = TR_KEY; t.res = KEY_PGDN; end
			end
			ST_BRACKET2: begin
				if (b inside {["A":"E"]}) begin
					d      = b - 8'("A");
					t.code = TR_KEY;
					t.res  = d[4:0];
				end
			end
			default: begin
				if (st >= ST_NUM_LO && st <= ST_NUM_HI && b == "~") begin
					t.code = TR_KEY;
					t.res  = st - ST_NUM_LO;
				end
			end
		endcase
		// Digit states move on only where the table has an entry.
		if (nx != ST_IDLE) begin
			t.code = TR_CONT;
			t.ns   = nx;
		end
		return t;
	endfunction

endpackage

// ===== src/aksd_front.sv =====
// ----------------------------------------------------------------------------
// aksd_front
// Accepts input words, runs the escape sequence parser and the timeout
// counter, and issues one command per input that produces results.
// ----------------------------------------------------------------------------
module aksd_front import aksd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	input  logic       in_kind,
	input  logic [7:0] in_byte,
	output logic       in_ready,
	output logic       push,
	output cmd_t       push_cmd,
	input  logic       queue_full
);

	logic [7:0]      timeout_q;
	pstate_t         st_q, st_d;
	logic [7:0]      wait_q, wait_d;
	logic [2:0]      cnt_q, cnt_d;
	logic [3:0][7:0] rq_q, rq_d;
	logic [7:0]      wait_inc;
	logic            accept;
	trans_t          tr;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign wait_inc = (wait_q == WAIT_MAX) ? wait_q : wait_q + 8'd1;
	assign tr       = transition(st_q, in_byte);

	// Timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	// Parser next state and command.
	always_comb begin
		st_d     = st_q;
		wait_d   = wait_q;
		cnt_d    = cnt_q;
		rq_d     = rq_q;
		push     = 1'b0;
		push_cmd = '{rcnt: cnt_q, rbytes: rq_q, tail: 1'b0, tail_special: 1'b0,
			tail_char: 8'd0, tail_key: 5'd0};
		if (accept) begin
			if (in_kind) begin
				// Tick: count only inside a sequence, flush on timeout.
				if (st_q != ST_IDLE) begin
					wait_d = wait_inc;
					if (wait_inc >= timeout_q) begin
						push  = 1'b1;
						st_d  = ST_IDLE;
						wait_d = 8'd0;
						cnt_d = 3'd0;
					end
				end
			end else if (st_q == ST_IDLE) begin
				if (in_byte == ESC_BYTE) begin
					st_d    = ST_ESC;
					wait_d  = 8'd0;
					rq_d[0] = ESC_BYTE;
					cnt_d   = 3'd1;
				end else begin
					push               = 1'b1;
					push_cmd.rcnt      = 3'd0;
					push_cmd.tail      = 1'b1;
					push_cmd.tail_char = in_byte;
				end
			end else begin
				wait_d = 8'd0;
				if (tr.code == TR_CONT && cnt_q < REPLAY_MAX) begin
					rq_d[cnt_q[1:0]] = in_byte;
					cnt_d = cnt_q + 3'd1;
					st_d  = tr.ns;
				end else begin
					push     = 1'b1;
					push_cmd.tail = 1'b1;
					case (tr.code)
						TR_KEY: begin
							push_cmd.rcnt         = 3'd0;
							push_cmd.tail_special = 1'b1;
							push_cmd.tail_key     = tr.res;
						end
						TR_CHAR: begin
							push_cmd.rcnt      = 3'd0;
							push_cmd.tail_char = {3'd0, tr.res};
						end
						default: begin
							// Bad byte: replay what was consumed, then the byte.
							push_cmd.tail_char = in_byte;
						end
					endcase
					st_d  = ST_IDLE;
					cnt_d = 3'd0;
				end
			end
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			wait_q <= 8'd0;
			cnt_q  <= 3'd0;
		end else begin
			st_q   <= st_d;
			wait_q <= wait_d;
			cnt_q  <= cnt_d;
		end
	end

	// Consumed bytes hold no reset value.
	always_ff @(posedge clk) begin
		rq_q <= rq_d;
	end

endmodule

// ===== src/aksd_queue.sv =====
// ----------------------------------------------------------------------------
// aksd_queue
// Short first-in first-out queue of commands between parser and output.
// ----------------------------------------------------------------------------
module aksd_queue import aksd_pkg::*; #(
	parameter int unsigned DEPTH = AKSD_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== src/aksd_back.sv =====
// ----------------------------------------------------------------------------
// aksd_back
// Expands each command into result words, one per cycle while the output is
// not stalled, through an output register.
// ----------------------------------------------------------------------------
module aksd_back import aksd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_special,
	output logic [7:0] out_char,
	output logic [4:0] out_key,
	output logic       out_last
);

	logic [2:0] idx_q;
	logic [2:0] total;
	logic       load;
	logic       is_last;
	logic       in_replay;
	logic       valid_q;
	logic       special_q, last_q;
	logic [7:0] char_q;
	logic [4:0] key_q;

	assign total     = head.rcnt + {2'd0, head.tail};
	assign load      = !empty && (!valid_q || out_ready);
	assign is_last   = (idx_q + 3'd1 == total);
	assign in_replay = (idx_q < head.rcnt);
	assign pop       = load && is_last;

	// Result index within the current command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
		end else if (load) begin
			idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= is_last;
			if (in_replay) begin
				special_q <= 1'b0;
				char_q    <= head.rbytes[idx_q[1:0]];
				key_q     <= 5'd0;
			end else begin
				special_q <= head.tail_special;
				char_q    <= head.tail_special ? 8'd0 : head.tail_char;
				key_q     <= head.tail_special ? head.tail_key : 5'd0;
			end
		end
	end

	assign out_valid   = valid_q;
	assign out_special = special_q;
	assign out_char    = char_q;
	assign out_key     = key_q;
	assign out_last    = last_q;

endmodule

// ===== src/ansi_key_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// ansi_key_sequence_decoder
// Decodes terminal escape sequences into special key ids, replaying the
// consumed bytes as plain characters on a bad byte or an inter-byte timeout.
// ----------------------------------------------------------------------------
// Path: an accepted input word goes into the command queue, and its first
// result word then into the output register. Throughput: one input word per
// cycle while the command queue has room; the output expander sends one
// result word per cycle while not stalled, zero to five results per input.
// Reset: asynchronous, active low; parser idle, queue empty, timeout 10.
// ----------------------------------------------------------------------------
module ansi_key_sequence_decoder import aksd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = AKSD_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] char_code, [12:8] key_id, [15:13] zero
	output logic        m_tuser,   // [0] is_special
	output logic        m_tlast
);

	logic       push, pop, full, empty;
	cmd_t       push_cmd, head;
	logic [7:0] out_char;
	logic [4:0] out_key;

	aksd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (s_tvalid),
		.in_kind    (s_tuser),
		.in_byte    (s_tdata),
		.in_ready   (s_tready),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (full)
	);

	aksd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full),
		.pop     (pop),
		.head    (head),
		.empty   (empty)
	);

	aksd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_special(m_tuser),
		.out_char   (out_char),
		.out_key    (out_key),
		.out_last   (m_tlast)
	);

	// Pack the result word.
	assign m_tdata = {3'd0, out_key, out_char};

endmodule

// ===== test/ansi_key_sequence_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// ansi_key_sequence_decoder_tb
// Self-checking testbench for the escape sequence key decoder. Bytes and time
// ticks are streamed in with random bursts and gaps, while the result side
// stalls on changing ready patterns. A behavioral decoder inside the bench
// predicts every result word, and each word that leaves the block is compared
// field by field. Directed tests cover each sequence form, replay on a bad
// byte and on timeout. Random traffic then runs under several timeout settings.
// ----------------------------------------------------------------------------
module ansi_key_sequence_decoder_tb;
	import aksd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_TICK   = 1'b1;
	localparam int   CYCLE_LIMIT = 1000000;
	localparam int   SETTLE_CYCLES = 16;

	// Digit tables of the decoder: next state after a digit in each state.
	localparam pstate_t CSI_DIGIT_NEXT [6] = '{5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9};
	localparam pstate_t ONE_DIGIT_NEXT [9] = '{5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
		5'd0, 5'd16, 5'd17, 5'd18};
	localparam pstate_t TWO_DIGIT_NEXT [10] = '{5'd19, 5'd20, 5'd0, 5'd21, 5'd22,
		5'd23, 5'd24, 5'd0, 5'd25, 5'd26};
	localparam pstate_t THREE_DIGIT_NEXT [4] = '{5'd27, 5'd28, 5'd29, 5'd30};

	typedef struct {
		logic       is_special;
		logic [7:0] char_code;
		logic [4:0] key_id;
		logic       last;
	} key_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	// Decoder state of the bench.
	pstate_t     dec_state;
	logic [7:0]  dec_wait;
	logic [7:0]  dec_timeout;
	logic [7:0]  consumed_q[$];
	key_result_t key_results_q[$];

	logic [7:0]  seq_buf[$];
	logic        valid_q;
	int          burst_left;
	int          fail_count;
	int          words_sent;
	int          bytes_sent;
	int          results_checked;
	int          settings_used;

	ansi_key_sequence_decoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// One parser step for a byte inside a sequence.
	function automatic tr_code_t next_step(input pstate_t st, input logic [7:0] b,
		output pstate_t ns, output logic [4:0] res);
		tr_code_t code;
		pstate_t  digit_ns;
		code     = TR_BAD;
		digit_ns = ST_IDLE;
		ns       = ST_IDLE;
		res      = '0;
		case (st)
			ST_ESC: begin
				if (b == "O") begin
					code = TR_CONT;
					ns   = ST_SS3;
				end else if (b == "[") begin
					code = TR_CONT;
					ns   = ST_CSI;
				end
			end
			ST_SS3: begin
				if (b >= "P" && b <= "S") begin
					code = TR_KEY;
					res  = 5'(b - "P");
				end
			end
			ST_CSI: begin
				code = TR_KEY;
				case (b)
					"A": res = KEY_UP;
					"B": res = KEY_DOWN;
					"C": res = KEY_RIGHT;
					"D": res = KEY_LEFT;
					"F": res = KEY_END;
					"H": res = KEY_HOME;
					"[": begin
						code = TR_CONT;
						ns   = ST_BRACKET2;
					end
					default: begin
						code = TR_BAD;
						if (b >= "1" && b <= "6") begin
							code = TR_CONT;
							ns   = CSI_DIGIT_NEXT[b - "1"];
						end
					end
				endcase
			end
			ST_ONE: begin
				if (b == "~") begin
					code = TR_KEY;
					res  = KEY_HOME;
				end else if (b >= "1" && b <= "9") begin
					digit_ns = ONE_DIGIT_NEXT[b - "1"];
				end
			end
			ST_TWO: begin
				if (b == "~") begin
					code = TR_KEY;
					res  = KEY_INSERT;
				end else if (b >= "0" && b <= "9") begin
					digit_ns = TWO_DIGIT_NEXT[b - "0"];
				end
			end
			ST_THREE: begin
				if (b == "~") begin
					code = TR_CHAR;
					res  = CHAR_DEL;
				end else if (b >= "1" && b <= "4") begin
					digit_ns = THREE_DIGIT_NEXT[b - "1"];
				end
			end
			ST_FOUR: begin
				if (b == "~") begin
					code = TR_KEY;
					res  = KEY_END;
				end
			end
			ST_FIVE: begin
				if (b == "~") begin
					code = TR_KEY;
					res  = KEY_PGUP;
				end
			end
			ST_SIX: begin
				if (b == "~") begin
					code = TR_KEY;
					res  = KEY_PGDN;
				end
			end
			ST_BRACKET2: begin
				if (b >= "A" && b <= "E") begin
					code = TR_KEY;
					res  = 5'(b - "A");
				end
			end
			default: begin
				if (st >= ST_NUM_LO && st <= ST_NUM_HI && b == "~") begin
					code = TR_KEY;
					res  = 5'(st - ST_NUM_LO);
				end
			end
		endcase
		// A digit continues only where its table has an entry.
		if (digit_ns != ST_IDLE) begin
			code = TR_CONT;
			ns   = digit_ns;
		end
		return code;
	endfunction

	task automatic push_result(input logic special, input logic [7:0] ch,
		input logic [4:0] key);
		key_result_t r;
		r.is_special = special;
		r.char_code  = special ? 8'd0 : ch;
		r.key_id     = special ? key : 5'd0;
		r.last       = 1'b0;
		key_results_q.push_back(r);
	endtask

	task automatic replay_consumed();
		foreach (consumed_q[i])
			push_result(1'b0, consumed_q[i], 5'd0);
	endtask

	task automatic return_to_idle();
		dec_state = ST_IDLE;
		dec_wait  = '0;
		consumed_q.delete();
	endtask

	// Predicts the result words that one accepted word causes.
	task automatic decode_word(input logic kind, input logic [7:0] b);
		pstate_t     ns;
		logic [4:0]  res;
		tr_code_t    code;
		int          first;
		key_result_t tail;
		first = key_results_q.size();
		if (kind == KIND_TICK) begin
			if (dec_state != ST_IDLE) begin
				if (dec_wait != WAIT_MAX)
					dec_wait++;
				if (dec_wait >= dec_timeout) begin
					replay_consumed();
					return_to_idle();
				end
			end
		end else if (dec_state == ST_IDLE) begin
			if (b == ESC_BYTE) begin
				dec_state = ST_ESC;
				dec_wait  = '0;
				consumed_q.delete();
				consumed_q.push_back(ESC_BYTE);
			end else begin
				push_result(1'b0, b, 5'd0);
			end
		end else begin
			dec_wait = '0;
			code = next_step(dec_state, b, ns, res);
			if (code == TR_CONT && consumed_q.size() < int'(REPLAY_MAX)) begin
				consumed_q.push_back(b);
				dec_state = ns;
			end else begin
				case (code)
					TR_KEY:  push_result(1'b1, 8'd0, res);
					TR_CHAR: push_result(1'b0, 8'(res), 5'd0);
					default: begin
						replay_consumed();
						push_result(1'b0, b, 5'd0);
					end
				endcase
				return_to_idle();
			end
		end
		// The final result of this word carries tlast.
		if (key_results_q.size() > first) begin
			tail      = key_results_q.pop_back();
			tail.last = 1'b1;
			key_results_q.push_back(tail);
		end
	endtask

	task automatic release_bus();
		if (valid_q) begin
			s_tvalid <= 1'b0;
			valid_q = 1'b0;
		end
	endtask

	// Sends one word, in bursts of random length with random gaps between.
	task automatic send_word(input logic kind, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				release_bus();
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		valid_q = 1'b1;
		s_tuser <= kind;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (kind == KIND_BYTE)
			bytes_sent++;
		decode_word(kind, b);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_word(KIND_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_esc_seq(input string tail);
		send_word(KIND_BYTE, ESC_BYTE);
		for (int i = 0; i < tail.len(); i++)
			send_word(KIND_BYTE, tail[i]);
	endtask

	// Most ticks that can pass in a sequence without a flush.
	function automatic int quiet_ticks();
		return (dec_timeout <= 8'd1) ? 0 : int'(dec_timeout) - 1;
	endfunction

	task automatic hold_until_drained();
		release_bus();
		do @(posedge clk); while (key_results_q.size() != 0);
	endtask

	// Waits for every result, lets the pipeline settle, then writes the timeout.
	task automatic set_timeout(input logic [7:0] ticks);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ticks;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		dec_timeout = ticks;
		settings_used++;
	endtask

	// Fills seq_buf with one well-formed key sequence.
	task automatic build_key_sequence();
		int d;
		int lead;
		seq_buf.delete();
		seq_buf.push_back(ESC_BYTE);
		case ($urandom_range(0, 5))
			0: begin
				seq_buf.push_back("O");
				seq_buf.push_back(8'("P" + $urandom_range(0, 3)));
			end
			1: begin
				seq_buf.push_back("[");
				case ($urandom_range(0, 5))
					0: seq_buf.push_back("A");
					1: seq_buf.push_back("B");
					2: seq_buf.push_back("C");
					3: seq_buf.push_back("D");
					4: seq_buf.push_back("F");
					default: seq_buf.push_back("H");
				endcase
			end
			2: begin
				seq_buf.push_back("[");
				seq_buf.push_back("[");
				seq_buf.push_back(8'("A" + $urandom_range(0, 4)));
			end
			3: begin
				seq_buf.push_back("[");
				seq_buf.push_back(8'("1" + $urandom_range(0, 5)));
				seq_buf.push_back("~");
			end
			default: begin
				lead = $urandom_range(1, 3);
				case (lead)
					1: do d = $urandom_range(1, 9); while (d == 6);
					2: do d = $urandom_range(0, 9); while (d == 2 || d == 7);
					default: d = $urandom_range(1, 4);
				endcase
				seq_buf.push_back("[");
				seq_buf.push_back(8'("0" + lead));
				seq_buf.push_back(8'("0" + d));
				seq_buf.push_back("~");
			end
		endcase
	endtask

	// Sends the first n bytes of seq_buf with ticks between that stay short
	// of the timeout.
	task automatic send_seq_prefix(input int n);
		int q;
		int k;
		for (int i = 0; i < n; i++) begin
			q = quiet_ticks();
			if (i > 0 && $urandom_range(0, 3) == 0) begin
				k = $urandom_range(0, (q < 3) ? q : 3);
				if (q <= 20 && $urandom_range(0, 7) == 0)
					k = q;
				send_ticks(k);
			end
			send_word(KIND_BYTE, seq_buf[i]);
		end
	endtask

	task automatic test_directed_keys();
		send_word(KIND_BYTE, 8'h00);
		send_word(KIND_BYTE, 8'hFF);
		send_word(KIND_BYTE, "a");
		send_word(KIND_TICK, 8'hA5);
		send_esc_seq("OP");
		send_esc_seq("OS");
		send_esc_seq("[A");
		send_esc_seq("[H");
		send_esc_seq("[1~");
		send_esc_seq("[2~");
		send_esc_seq("[3~");
		send_esc_seq("[6~");
		send_esc_seq("[[A");
		send_esc_seq("[[E");
		send_esc_seq("[11~");
		send_esc_seq("[34~");
		send_esc_seq("[29~");
	endtask

	task automatic test_replay_cases();
		// A digit with no table entry, and a byte that breaks a long sequence.
		send_esc_seq("[16");
		send_esc_seq("[15x");
		send_esc_seq("OT");
		// ESC as the bad byte is not decoded again; the O after it is plain.
		send_esc_seq("[");
		send_word(KIND_BYTE, ESC_BYTE);
		send_word(KIND_BYTE, "O");
		// Ticks one short of the timeout, then a byte clears the count.
		send_esc_seq("[2");
		send_ticks(9);
		send_word(KIND_BYTE, "~");
		// Timeout flush, then a tick while idle.
		send_esc_seq("[2");
		send_ticks(10);
		send_word(KIND_TICK, 8'h00);
		// A zero timeout flushes on the first tick.
		set_timeout(8'd0);
		send_esc_seq("O");
		send_ticks(1);
		// Largest timeout.
		set_timeout(8'd255);
		send_esc_seq("[");
		send_ticks(255);
	endtask

	task automatic test_random_traffic(input logic [7:0] ticks, input int n_bytes);
		int start;
		int sel;
		int cut;
		set_timeout(ticks);
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			if ($urandom_range(0, 49) == 0)
				hold_until_drained();
			sel = $urandom_range(0, 99);
			build_key_sequence();
			if (sel < 60) begin
				send_seq_prefix(seq_buf.size());
			end else if (sel < 75) begin
				cut = $urandom_range(1, seq_buf.size() - 1);
				send_seq_prefix(cut);
				send_word(KIND_BYTE, 8'($urandom_range(0, 255)));
			end else if (sel < 85) begin
				cut = $urandom_range(1, seq_buf.size() - 1);
				send_seq_prefix(cut);
				send_ticks(quiet_ticks() + 1 + $urandom_range(0, 2));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 3) == 0)
						send_word(KIND_TICK, 8'($urandom_range(0, 255)));
					else if ($urandom_range(0, 7) == 0)
						send_word(KIND_BYTE, ESC_BYTE);
					else
						send_word(KIND_BYTE, 8'($urandom_range(0, 255)));
				end
			end
		end
		// Leave the parser idle so the next setting starts clean.
		send_word(KIND_BYTE, 8'h00);
	endtask

	// Result side stalls on a pattern that changes now and then.
	initial begin : ready_pattern
		logic [15:0] pat;
		int          hold;
		m_tready <= 1'b0;
		pat  = 16'hFFFF;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				hold = $urandom_range(20, 300);
				case ($urandom_range(0, 3))
					0: pat = 16'hFFFF;
					1: pat = 16'($urandom()) | 16'h0001;
					2: pat = 16'h5555;
					default: pat = 16'h0001 << $urandom_range(0, 15);
				endcase
			end
			hold--;
			m_tready <= pat[0];
			pat = {pat[0], pat[15:1]};
		end
	end

	// Compares each accepted result word with the oldest prediction.
	always @(posedge clk) begin : result_check
		key_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (key_results_q.size() == 0) begin
				$error("unexpected result word: tuser %0b tdata %h tlast %0b",
					m_tuser, m_tdata, m_tlast);
				fail_count++;
			end else begin
				want = key_results_q.pop_front();
				results_checked++;
				if (m_tuser !== want.is_special) begin
					$error("is_special: expected %0d, got %0d", want.is_special, m_tuser);
					fail_count++;
				end
				if (m_tdata[7:0] !== want.char_code) begin
					$error("char_code: expected %0d, got %0d", want.char_code, m_tdata[7:0]);
					fail_count++;
				end
				if (m_tdata[12:8] !== want.key_id) begin
					$error("key_id: expected %0d, got %0d", want.key_id, m_tdata[12:8]);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : main_sequence
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= 8'd0;
		s_tvalid    <= 1'b0;
		s_tdata     <= 8'd0;
		s_tuser     <= KIND_BYTE;
		valid_q         = 1'b0;
		burst_left      = 0;
		fail_count      = 0;
		words_sent      = 0;
		bytes_sent      = 0;
		results_checked = 0;
		settings_used   = 1;
		dec_timeout     = TIMEOUT_RESET;
		return_to_idle();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_keys();
		test_replay_cases();
		test_random_traffic(8'd1, 25);
		test_random_traffic(8'd3, 25);
		test_random_traffic(8'($urandom_range(2, 20)), 25);
		test_random_traffic(TIMEOUT_RESET, 25);

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d input words (%0d bytes) under %0d timeout settings.",
			words_sent, bytes_sent, settings_used);
		$display("Checked %0d result words, %0d mismatches.", results_checked, fail_count);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
